/* sv/eebe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package eebe_pkg;

    localparam int COORD_W = 16;
    localparam int VEC_W   = 20;
    localparam int TERM_W  = 18;
    localparam int ACC_W   = 21;
    localparam int PROD_W  = 2 * TERM_W;

    localparam logic [1:0] KIND_VALUE    = 2'd0;
    localparam logic [1:0] KIND_CURL     = 2'd1;
    localparam logic [1:0] KIND_PERP     = 2'd2;
    localparam logic [1:0] KIND_DIV_PERP = 2'd3;

    localparam logic [2:0] TYPE_LINE  = 3'd0;
    localparam logic [2:0] TYPE_TRI   = 3'd1;
    localparam logic [2:0] TYPE_QUAD  = 3'd2;
    localparam logic [2:0] TYPE_TET   = 3'd3;
    localparam logic [2:0] TYPE_HEX   = 3'd4;
    localparam logic [2:0] TYPE_PRISM = 3'd5;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_EDGE  = 2'd1;
    localparam logic [1:0] STATUS_BAD_TYPE  = 2'd2;

    localparam logic [1:0] SRC_LIN = 2'd0;
    localparam logic [1:0] SRC_P1  = 2'd1;
    localparam logic [1:0] SRC_P2  = 2'd2;

    // Q14 constants
    localparam logic signed [TERM_W-1:0] ONE_Q14     = 18'sd16384;
    localparam logic signed [TERM_W-1:0] TWO_Q14     = 18'sd32768;
    localparam logic signed [TERM_W-1:0] HALF_Q14    = 18'sd8192;
    localparam logic signed [TERM_W-1:0] QUARTER_Q14 = 18'sd4096;

    localparam logic signed [ACC_W-1:0] VEC_MAX = 21'sd524287;
    localparam logic signed [ACC_W-1:0] VEC_MIN = -21'sd524288;

    typedef struct packed {
        logic [1:0]                kind;
        logic [2:0]                element_type;
        logic [3:0]                edge_number;
        logic                      edge_reversed;
        logic signed [COORD_W-1:0] coord_u;
        logic signed [COORD_W-1:0] coord_v;
        logic signed [COORD_W-1:0] coord_w;
    } in_word_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] vec_x;
        logic signed [VEC_W-1:0] vec_y;
        logic signed [VEC_W-1:0] vec_z;
        logic [1:0]              status;
    } out_word_t;

endpackage

`default_nettype wire

/* sv/edge_element_basis_evaluator_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// First-order edge-element basis evaluator. Each input word names a result
// kind (value, curl, perpendicular facet, divergence of perpendicular facet),
// a reference element type, a local edge, an orientation bit and a point
// u, v, w in signed Q2.14; the block returns one vector in signed Q6.14,
// saturated, with a status code (bad edge or unknown type gives a zero
// vector). The block holds no state: a word passes an input register, one
// stage of logic built around two 18x18 multipliers, and a result register,
// and one word is taken every cycle while the result side keeps up.

module edge_element_basis_evaluator_top (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_valid,
    output logic                     s_ready,
    input  wire eebe_pkg::in_word_t  s_data,
    output logic                     m_valid,
    input  wire                      m_ready,
    output eebe_pkg::out_word_t      m_data
);

    eebe_pkg::in_word_t  in_reg;
    logic                in_valid_reg;
    logic                in_valid_next;
    eebe_pkg::out_word_t out_reg;
    eebe_pkg::out_word_t out_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_free;

    logic signed [eebe_pkg::TERM_W-1:0] u, v, w, nu, nv, nw;
    logic signed [eebe_pkg::TERM_W-1:0] omu, opu, omv, opv, omw, opw;
    logic signed [eebe_pkg::TERM_W-1:0] umo, vmo, wmo, nopu, nopv, nopw;
    logic signed [eebe_pkg::TERM_W-1:0] omvw, omuw, omuv;

    logic [1:0]                         st;
    logic                               is_curl;
    logic                               mul_hex;
    logic signed [eebe_pkg::TERM_W-1:0] a1, b1, a2, b2;
    logic [1:0]                         src_x, src_y, src_z;
    logic signed [eebe_pkg::TERM_W-1:0] lin_x, lin_y, lin_z;
    logic [1:0]                         sh_x, sh_y, sh_z;

    logic signed [eebe_pkg::PROD_W-1:0] p1, p2, p1_r17, p1_r15, p2_r15;
    logic signed [eebe_pkg::ACC_W-1:0]  r1, r2;
    logic signed [eebe_pkg::ACC_W-1:0]  c_x, c_y, c_z;
    logic signed [eebe_pkg::ACC_W-1:0]  n_x, n_y, n_z;
    logic signed [eebe_pkg::ACC_W-1:0]  o_x, o_y, o_z;

    function automatic logic signed [eebe_pkg::ACC_W-1:0] rnd_lin(
        input logic signed [eebe_pkg::TERM_W-1:0] x,
        input logic [1:0]                         sh
    );
        logic signed [eebe_pkg::ACC_W-1:0] xe;
        logic signed [eebe_pkg::ACC_W-1:0] res;
        xe = eebe_pkg::ACC_W'(x);
        case (sh)
            2'd0:    res = xe;
            2'd1:    res = (xe + 21'sd1) >>> 1;
            2'd2:    res = (xe + 21'sd2) >>> 2;
            2'd3:    res = (xe + 21'sd4) >>> 3;
            default: res = xe;
        endcase
        return res;
    endfunction

    function automatic logic signed [eebe_pkg::ACC_W-1:0] sel_src(
        input logic [1:0]                        src,
        input logic signed [eebe_pkg::ACC_W-1:0] lin,
        input logic signed [eebe_pkg::ACC_W-1:0] q1,
        input logic signed [eebe_pkg::ACC_W-1:0] q2
    );
        logic signed [eebe_pkg::ACC_W-1:0] res;
        case (src)
            eebe_pkg::SRC_P1: res = q1;
            eebe_pkg::SRC_P2: res = q2;
            default:          res = lin;
        endcase
        return res;
    endfunction

    function automatic logic signed [eebe_pkg::VEC_W-1:0] sat(
        input logic signed [eebe_pkg::ACC_W-1:0] x
    );
        logic signed [eebe_pkg::VEC_W-1:0] res;
        if (x > eebe_pkg::VEC_MAX) begin
            res = eebe_pkg::VEC_MAX[eebe_pkg::VEC_W-1:0];
        end else if (x < eebe_pkg::VEC_MIN) begin
            res = eebe_pkg::VEC_MIN[eebe_pkg::VEC_W-1:0];
        end else begin
            res = x[eebe_pkg::VEC_W-1:0];
        end
        return res;
    endfunction

    // handshake
    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_free;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (out_free && in_valid_reg) begin
            out_reg <= out_next;
        end
    end

    // coordinate terms
    always_comb begin
        u    = eebe_pkg::TERM_W'(in_reg.coord_u);
        v    = eebe_pkg::TERM_W'(in_reg.coord_v);
        w    = eebe_pkg::TERM_W'(in_reg.coord_w);
        nu   = -u;
        nv   = -v;
        nw   = -w;
        omu  = eebe_pkg::ONE_Q14 - u;
        opu  = eebe_pkg::ONE_Q14 + u;
        omv  = eebe_pkg::ONE_Q14 - v;
        opv  = eebe_pkg::ONE_Q14 + v;
        omw  = eebe_pkg::ONE_Q14 - w;
        opw  = eebe_pkg::ONE_Q14 + w;
        umo  = u - eebe_pkg::ONE_Q14;
        vmo  = v - eebe_pkg::ONE_Q14;
        wmo  = w - eebe_pkg::ONE_Q14;
        nopu = -eebe_pkg::ONE_Q14 - u;
        nopv = -eebe_pkg::ONE_Q14 - v;
        nopw = -eebe_pkg::ONE_Q14 - w;
        omvw = eebe_pkg::ONE_Q14 - v - w;
        omuw = eebe_pkg::ONE_Q14 - u - w;
        omuv = eebe_pkg::ONE_Q14 - u - v;
    end

    // per-edge decode
    always_comb begin
        is_curl = (in_reg.kind == eebe_pkg::KIND_CURL) ||
                  (in_reg.kind == eebe_pkg::KIND_DIV_PERP);
        st      = eebe_pkg::STATUS_OK;
        mul_hex = 1'b0;
        a1      = '0;
        b1      = '0;
        a2      = '0;
        b2      = '0;
        src_x   = eebe_pkg::SRC_LIN;
        src_y   = eebe_pkg::SRC_LIN;
        src_z   = eebe_pkg::SRC_LIN;
        lin_x   = '0;
        lin_y   = '0;
        lin_z   = '0;
        sh_x    = 2'd0;
        sh_y    = 2'd0;
        sh_z    = 2'd0;
        case (in_reg.element_type)
            eebe_pkg::TYPE_LINE: begin
                if (in_reg.edge_number != 4'd1) begin
                    st = eebe_pkg::STATUS_BAD_EDGE;
                end else if (!is_curl) begin
                    lin_x = eebe_pkg::HALF_Q14;
                end
            end
            eebe_pkg::TYPE_TRI: begin
                case (in_reg.edge_number)
                    4'd1: begin
                        if (is_curl) begin
                            lin_z = eebe_pkg::TWO_Q14;
                        end else begin
                            lin_x = omv; lin_y = u;
                        end
                    end
                    4'd2: begin
                        if (is_curl) begin
                            lin_z = -eebe_pkg::TWO_Q14;
                        end else begin
                            lin_x = v; lin_y = omu;
                        end
                    end
                    4'd3: begin
                        if (is_curl) begin
                            lin_z = eebe_pkg::TWO_Q14;
                        end else begin
                            lin_x = nv; lin_y = u;
                        end
                    end
                    default: st = eebe_pkg::STATUS_BAD_EDGE;
                endcase
            end
            eebe_pkg::TYPE_QUAD: begin
                case (in_reg.edge_number)
                    4'd1: begin
                        if (is_curl) begin
                            lin_z = eebe_pkg::QUARTER_Q14;
                        end else begin
                            lin_x = omv; sh_x = 2'd2;
                        end
                    end
                    4'd2: begin
                        if (is_curl) begin
                            lin_z = -eebe_pkg::QUARTER_Q14;
                        end else begin
                            lin_y = omu; sh_y = 2'd2;
                        end
                    end
                    4'd3: begin
                        if (is_curl) begin
                            lin_z = eebe_pkg::QUARTER_Q14;
                        end else begin
                            lin_y = opu; sh_y = 2'd2;
                        end
                    end
                    4'd4: begin
                        if (is_curl) begin
                            lin_z = eebe_pkg::QUARTER_Q14;
                        end else begin
                            lin_x = nopv; sh_x = 2'd2;
                        end
                    end
                    default: st = eebe_pkg::STATUS_BAD_EDGE;
                endcase
            end
            eebe_pkg::TYPE_TET: begin
                case (in_reg.edge_number)
                    4'd1: begin
                        if (is_curl) begin
                            lin_y = -eebe_pkg::TWO_Q14; lin_z = eebe_pkg::TWO_Q14;
                        end else begin
                            lin_x = omvw; lin_y = u; lin_z = u;
                        end
                    end
                    4'd2: begin
                        if (is_curl) begin
                            lin_x = eebe_pkg::TWO_Q14; lin_z = -eebe_pkg::TWO_Q14;
                        end else begin
                            lin_x = v; lin_y = omuw; lin_z = v;
                        end
                    end
                    4'd3: begin
                        if (is_curl) begin
                            lin_x = -eebe_pkg::TWO_Q14; lin_y = eebe_pkg::TWO_Q14;
                        end else begin
                            lin_x = w; lin_y = w; lin_z = omuv;
                        end
                    end
                    4'd4: begin
                        if (is_curl) begin
                            lin_z = eebe_pkg::TWO_Q14;
                        end else begin
                            lin_x = nv; lin_y = u;
                        end
                    end
                    4'd5: begin
                        if (is_curl) begin
                            lin_y = -eebe_pkg::TWO_Q14;
                        end else begin
                            lin_x = nw; lin_z = u;
                        end
                    end
                    4'd6: begin
                        if (is_curl) begin
                            lin_x = eebe_pkg::TWO_Q14;
                        end else begin
                            lin_y = nw; lin_z = v;
                        end
                    end
                    default: st = eebe_pkg::STATUS_BAD_EDGE;
                endcase
            end
            eebe_pkg::TYPE_HEX: begin
                mul_hex = 1'b1;
                sh_x    = 2'd3;
                sh_y    = 2'd3;
                sh_z    = 2'd3;
                case (in_reg.edge_number)
                    4'd1: begin
                        a1 = omv; b1 = omw; src_x = eebe_pkg::SRC_P1;
                        lin_y = vmo; lin_z = omw;
                    end
                    4'd6: begin
                        a1 = nopv; b1 = omw; src_x = eebe_pkg::SRC_P1;
                        lin_y = opv; lin_z = omw;
                    end
                    4'd9: begin
                        a1 = omv; b1 = opw; src_x = eebe_pkg::SRC_P1;
                        lin_y = omv; lin_z = opw;
                    end
                    4'd12: begin
                        a1 = nopv; b1 = opw; src_x = eebe_pkg::SRC_P1;
                        lin_y = nopv; lin_z = opw;
                    end
                    4'd2: begin
                        a1 = omu; b1 = omw; src_y = eebe_pkg::SRC_P1;
                        lin_x = omu; lin_z = wmo;
                    end
                    4'd4: begin
                        a1 = opu; b1 = omw; src_y = eebe_pkg::SRC_P1;
                        lin_x = opu; lin_z = omw;
                    end
                    4'd10: begin
                        a1 = omu; b1 = opw; src_y = eebe_pkg::SRC_P1;
                        lin_x = umo; lin_z = nopw;
                    end
                    4'd11: begin
                        a1 = opu; b1 = opw; src_y = eebe_pkg::SRC_P1;
                        lin_x = nopu; lin_z = opw;
                    end
                    4'd3: begin
                        a1 = omu; b1 = omv; src_z = eebe_pkg::SRC_P1;
                        lin_x = umo; lin_y = omv;
                    end
                    4'd5: begin
                        a1 = opu; b1 = omv; src_z = eebe_pkg::SRC_P1;
                        lin_x = nopu; lin_y = vmo;
                    end
                    4'd7: begin
                        a1 = opu; b1 = opv; src_z = eebe_pkg::SRC_P1;
                        lin_x = opu; lin_y = nopv;
                    end
                    4'd8: begin
                        a1 = omu; b1 = opv; src_z = eebe_pkg::SRC_P1;
                        lin_x = omu; lin_y = opv;
                    end
                    default: st = eebe_pkg::STATUS_BAD_EDGE;
                endcase
                // the value uses only the product, the curl only the linear terms
                if (is_curl) begin
                    src_x = eebe_pkg::SRC_LIN;
                    src_y = eebe_pkg::SRC_LIN;
                    src_z = eebe_pkg::SRC_LIN;
                end else begin
                    lin_x = '0;
                    lin_y = '0;
                    lin_z = '0;
                end
            end
            eebe_pkg::TYPE_PRISM: begin
                case (in_reg.edge_number)
                    4'd1: begin
                        if (is_curl) begin
                            lin_x = u; sh_x = 2'd1; lin_y = vmo; sh_y = 2'd1; lin_z = omw;
                        end else begin
                            a1 = omv; b1 = omw; a2 = u; b2 = omw;
                        end
                    end
                    4'd2: begin
                        if (is_curl) begin
                            lin_x = omu; sh_x = 2'd1; lin_y = nv; sh_y = 2'd1; lin_z = wmo;
                        end else begin
                            a1 = v; b1 = omw; a2 = omu; b2 = omw;
                        end
                    end
                    4'd3: begin
                        if (is_curl) begin
                            lin_x = -eebe_pkg::HALF_Q14; lin_y = eebe_pkg::HALF_Q14;
                        end else begin
                            lin_z = omuv; sh_z = 2'd1;
                        end
                    end
                    4'd4: begin
                        if (is_curl) begin
                            lin_x = u; sh_x = 2'd1; lin_y = v; sh_y = 2'd1; lin_z = omw;
                        end else begin
                            a1 = nv; b1 = omw; a2 = u; b2 = omw;
                        end
                    end
                    4'd5: begin
                        if (is_curl) begin
                            lin_y = -eebe_pkg::HALF_Q14;
                        end else begin
                            lin_z = u; sh_z = 2'd1;
                        end
                    end
                    4'd6: begin
                        if (is_curl) begin
                            lin_x = eebe_pkg::HALF_Q14;
                        end else begin
                            lin_z = v; sh_z = 2'd1;
                        end
                    end
                    4'd7: begin
                        if (is_curl) begin
                            lin_x = nu; sh_x = 2'd1; lin_y = omv; sh_y = 2'd1; lin_z = opw;
                        end else begin
                            a1 = omv; b1 = opw; a2 = u; b2 = opw;
                        end
                    end
                    4'd8: begin
                        if (is_curl) begin
                            lin_x = umo; sh_x = 2'd1; lin_y = v; sh_y = 2'd1; lin_z = nopw;
                        end else begin
                            a1 = v; b1 = opw; a2 = omu; b2 = opw;
                        end
                    end
                    4'd9: begin
                        if (is_curl) begin
                            lin_x = nu; sh_x = 2'd1; lin_y = nv; sh_y = 2'd1; lin_z = opw;
                        end else begin
                            a1 = nv; b1 = opw; a2 = u; b2 = opw;
                        end
                    end
                    default: st = eebe_pkg::STATUS_BAD_EDGE;
                endcase
                // products of edges 1, 2, 4, 7, 8 and 9 feed x and y
                if (!is_curl && (in_reg.edge_number == 4'd1 || in_reg.edge_number == 4'd2 ||
                                 in_reg.edge_number == 4'd4 || in_reg.edge_number == 4'd7 ||
                                 in_reg.edge_number == 4'd8 || in_reg.edge_number == 4'd9)) begin
                    src_x = eebe_pkg::SRC_P1;
                    src_y = eebe_pkg::SRC_P2;
                end
            end
            default: st = eebe_pkg::STATUS_BAD_TYPE;
        endcase
    end

    // products, rounded half up
    always_comb begin
        p1     = a1 * b1;
        p2     = a2 * b2;
        p1_r17 = (p1 + (eebe_pkg::PROD_W'(1) <<< 16)) >>> 17;
        p1_r15 = (p1 + (eebe_pkg::PROD_W'(1) <<< 14)) >>> 15;
        p2_r15 = (p2 + (eebe_pkg::PROD_W'(1) <<< 14)) >>> 15;
        r1     = mul_hex ? p1_r17[eebe_pkg::ACC_W-1:0] : p1_r15[eebe_pkg::ACC_W-1:0];
        r2     = p2_r15[eebe_pkg::ACC_W-1:0];
    end

    // orientation, rotation and saturation
    always_comb begin
        c_x = sel_src(src_x, rnd_lin(lin_x, sh_x), r1, r2);
        c_y = sel_src(src_y, rnd_lin(lin_y, sh_y), r1, r2);
        c_z = sel_src(src_z, rnd_lin(lin_z, sh_z), r1, r2);
        if (in_reg.edge_reversed) begin
            n_x = -c_x;
            n_y = -c_y;
            n_z = -c_z;
        end else begin
            n_x = c_x;
            n_y = c_y;
            n_z = c_z;
        end
        case (in_reg.kind)
            eebe_pkg::KIND_PERP: begin
                o_x = -n_y;
                o_y = n_x;
                o_z = n_z;
            end
            eebe_pkg::KIND_DIV_PERP: begin
                o_x = -n_z;
                o_y = n_y;
                o_z = '0;
            end
            default: begin
                o_x = n_x;
                o_y = n_y;
                o_z = n_z;
            end
        endcase
        out_next.status = st;
        if (st != eebe_pkg::STATUS_OK) begin
            out_next.vec_x = '0;
            out_next.vec_y = '0;
            out_next.vec_z = '0;
        end else begin
            out_next.vec_x = sat(o_x);
            out_next.vec_y = sat(o_y);
            out_next.vec_z = sat(o_z);
        end
    end

endmodule

`default_nettype wire
